// ===== src/selective_repeat_sender_window_defines.svh =====
// Assertion macros used by the checker file of the sender window.
// No dependencies; clk_i and rst_ni must exist in the using scope.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SRSW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SRSW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/srsw_pkg.sv =====
// Shared types and constants for the selective-repeat sender window.
// No dependencies.
package srsw_pkg;

  localparam int WINDOW    = 16;
  localparam int MAX_OUT   = 16;
  localparam int LIMIT_MAX = (WINDOW < MAX_OUT) ? WINDOW : MAX_OUT;
  localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int OCC_W     = $clog2(WINDOW + 1);
  localparam int SEQ_W     = 16;
  localparam int CNT_W     = 32;
  localparam int WSZ_W     = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_POLL    = 2'd1,
    OP_ACK     = 2'd2,
    OP_TIMEOUT = 2'd3
  } opcode_e;

  typedef struct packed {
    logic [1:0] opcode;
    seq_t       ack_seq;
  } in_item_t;

  typedef struct packed {
    logic kind;
    seq_t frame_seq;
    logic last;
    seq_t window_base;
    seq_t next_seq;
    logic done_res;
    logic ack_matched;
    cnt_t sent_count;
    cnt_t retry_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic refill;
    logic retx;
    logic ack_mark;
    logic slide;
    logic idx_clr;
    logic idx_inc;
    logic emit_status;
    logic emit_frame;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic head_acked;
    logic pend_any;
    logic cur_pend;
    logic cur_last;
  } dp_stat_t;

endpackage

// ===== src/srsw_in_if.sv =====
// Request channel: valid/ready plus one input item.
// Depends on srsw_pkg.
interface srsw_in_if;
  import srsw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/srsw_out_if.sv =====
// Result channel: valid/ready plus one result item.
// Depends on srsw_pkg.
interface srsw_out_if;
  import srsw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/srsw_ctrl.sv =====
// Sequencer for the sender window: walks each request through its steps.
// Depends on srsw_pkg.
module srsw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        opcode_i,
  output logic              in_ready_o,
  input  srsw_pkg::dp_stat_t stat_i,
  output srsw_pkg::dp_cmd_t  cmd_o
);
  import srsw_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REFILL  = 3'd1;
  localparam logic [2:0] S_ACKMARK = 3'd2;
  localparam logic [2:0] S_SLIDE   = 3'd3;
  localparam logic [2:0] S_STATUS  = 3'd4;
  localparam logic [2:0] S_SCAN    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (opcode_i)
            OP_START: begin
              cmd_o.clear = 1'b1;
              state_d     = S_REFILL;
            end
            OP_POLL: begin
              if (stat_i.pend_any) begin
                cmd_o.idx_clr = 1'b1;
                state_d       = S_SCAN;
              end else begin
                state_d = S_STATUS;
              end
            end
            OP_ACK: state_d = S_ACKMARK;
            OP_TIMEOUT: begin
              cmd_o.retx = 1'b1;
              state_d    = S_STATUS;
            end
            default: state_d = S_STATUS;
          endcase
        end
      end
      S_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = S_STATUS;
      end
      S_ACKMARK: begin
        cmd_o.ack_mark = 1'b1;
        state_d        = S_SLIDE;
      end
      S_SLIDE: begin
        if (stat_i.head_acked) begin
          cmd_o.slide = 1'b1;
        end else begin
          state_d = S_REFILL;
        end
      end
      S_STATUS: begin
        if (stat_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.cur_pend) begin
          if (stat_i.out_free) begin
            cmd_o.emit_frame = 1'b1;
            cmd_o.idx_inc    = 1'b1;
            if (stat_i.cur_last) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/srsw_dpath.sv =====
// Window state, counters, config registers and the result register.
// Depends on srsw_pkg.
module srsw_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [srsw_pkg::CFG_W-1:0]       cfg_data_i,
  input  srsw_pkg::seq_t                   ack_seq_i,
  input  srsw_pkg::dp_cmd_t                cmd_i,
  output srsw_pkg::dp_stat_t               stat_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output srsw_pkg::out_item_t              out_item_o
);
  import srsw_pkg::*;

  // (base + ofs) mod WINDOW, base < WINDOW and ofs small enough that one
  // subtract suffices
  function automatic slot_t slot_add(slot_t base, occ_t ofs);
    logic [OCC_W:0] sum;
    sum = (OCC_W+1)'(base) + (OCC_W+1)'(ofs);
    if (sum >= (OCC_W+1)'(WINDOW)) sum = sum - (OCC_W+1)'(WINDOW);
    return slot_t'(sum);
  endfunction

  seq_t              total_q;
  logic [WSZ_W-1:0]  wsize_q;
  logic [WINDOW-1:0] flags_q;
  slot_t             head_q;
  occ_t              occ_q;
  seq_t              base_q;
  seq_t              issue_q;
  cnt_t              tx_q;
  cnt_t              retx_q;
  seq_t              ack_q;
  logic              matched_q;
  occ_t              idx_q;
  logic              out_valid_q;
  out_item_t         out_q, out_d;

  occ_t              lim, room, fill;
  seq_t              avail, ack_off;
  slot_t             ack_slot, scan_slot;
  logic              ack_hit, done;
  logic [WINDOW-1:0] pend_vec, pend_rest;
  cnt_t              tx_inc, retx_inc;

  always_comb begin
    if (wsize_q == '0) begin
      lim = occ_t'(1);
    end else if (32'(wsize_q) > LIMIT_MAX) begin
      lim = occ_t'(LIMIT_MAX);
    end else begin
      lim = occ_t'(wsize_q);
    end
  end

  assign room  = (occ_q < lim) ? lim - occ_q : '0;
  assign avail = (issue_q < total_q) ? total_q - issue_q : '0;
  assign fill  = (avail < SEQ_W'(room)) ? occ_t'(avail) : room;

  assign ack_off  = ack_q - base_q;
  assign ack_slot = slot_add(head_q, occ_t'(ack_off));
  assign ack_hit  = (ack_off < SEQ_W'(occ_q)) && !flags_q[ack_slot];

  // window-order view of unacknowledged frames
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      pend_vec[i] = (occ_t'(i) < occ_q) && !flags_q[slot_add(head_q, occ_t'(i))];
    end
  end

  assign scan_slot = idx_q[SLOT_W-1:0];
  assign pend_rest = (pend_vec >> scan_slot) >> 1;

  assign tx_inc   = (tx_q == '1) ? tx_q : tx_q + cnt_t'(1);
  assign retx_inc = (retx_q == '1) ? retx_q : retx_q + cnt_t'(1);
  assign done     = (occ_q == '0) && (issue_q >= total_q);

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.head_acked = (occ_q != '0) && flags_q[head_q];
  assign stat_o.pend_any   = (pend_vec != '0);
  assign stat_o.cur_pend   = pend_vec[scan_slot];
  assign stat_o.cur_last   = (pend_rest == '0);

  always_comb begin
    out_d.kind        = cmd_i.emit_frame;
    out_d.frame_seq   = cmd_i.emit_frame ? base_q + SEQ_W'(idx_q) : '0;
    out_d.last        = cmd_i.emit_frame ? (pend_rest == '0) : 1'b1;
    out_d.window_base = base_q;
    out_d.next_seq    = issue_q;
    out_d.done_res    = done;
    out_d.ack_matched = cmd_i.emit_frame ? 1'b0 : matched_q;
    out_d.sent_count  = cmd_i.emit_frame ? tx_inc : tx_q;
    out_d.retry_count = retx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= seq_t'(1);
      wsize_q     <= WSZ_W'(1);
      flags_q     <= '0;
      head_q      <= '0;
      occ_q       <= '0;
      base_q      <= '0;
      issue_q     <= '0;
      tx_q        <= '0;
      retx_q      <= '0;
      matched_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TOTAL_FRAMES: total_q <= cfg_data_i[SEQ_W-1:0];
          CFG_WINDOW_SIZE:  wsize_q <= cfg_data_i[WSZ_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) matched_q <= 1'b0;
      if (cmd_i.clear) begin
        flags_q <= '0;
        head_q  <= '0;
        occ_q   <= '0;
        base_q  <= '0;
        issue_q <= '0;
        tx_q    <= '0;
        retx_q  <= '0;
      end
      if (cmd_i.refill) begin
        occ_q   <= occ_q + fill;
        issue_q <= issue_q + SEQ_W'(fill);
      end
      if (cmd_i.retx) retx_q <= retx_inc;
      if (cmd_i.ack_mark) begin
        matched_q <= ack_hit;
        if (ack_hit) flags_q[ack_slot] <= 1'b1;
      end
      if (cmd_i.slide) begin
        flags_q[head_q] <= 1'b0;
        head_q          <= slot_add(head_q, occ_t'(1));
        occ_q           <= occ_q - occ_t'(1);
        base_q          <= base_q + seq_t'(1);
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      if (cmd_i.idx_inc) idx_q <= idx_q + occ_t'(1);
      if (cmd_i.emit_frame) tx_q <= tx_inc;
      if (cmd_i.emit_status || cmd_i.emit_frame) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) ack_q <= ack_seq_i;
    if (cmd_i.emit_status || cmd_i.emit_frame) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== src/selective_repeat_sender_window.sv =====
// Top level of the selective-repeat sender window: sequencer plus datapath.
// Depends on srsw_pkg, srsw_in_if, srsw_out_if, srsw_ctrl, srsw_dpath.
//
//  channel    dir  handshake          payload
//  in_chan    in   valid/ready        opcode, ack_seq
//  out_chan   out  valid/ready        kind .. retry_count (one result)
//  cfg        in   cfg_we_i (no ack)  cfg_idx_i, cfg_data_i
//
// Steps: start refills the window and reports status; timeout counts a
//   retry and reports status; ack marks its frame, slides acknowledged
//   frames off the front, refills and reports status; an empty poll
//   reports status; a poll with pending frames sends each one in order.
// One request is worked on at a time; the sequencer accepts only when idle.
// Reset (async, active low) clears the window and both counters and sets
//   total_frames and window_size to 1; there is no clearing pass.
// A stalled result holds in the output register; the sequencer waits there
//   before producing the next one.
module selective_repeat_sender_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [srsw_pkg::CFG_W-1:0]     cfg_data_i,
  srsw_in_if.sink                        in_chan,
  srsw_out_if.source                     out_chan
);
  import srsw_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decodes the request and issues one command set per cycle
  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .opcode_i   (in_chan.payload.opcode),
    .in_ready_o (in_chan.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // window flags, sequence pointers, counters and the result register
  srsw_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ack_seq_i   (in_chan.payload.ack_seq),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_chan.ready),
    .out_valid_o (out_chan.valid),
    .out_item_o  (out_chan.payload)
  );

endmodule

// ===== src/srsw_checker.sv =====
// Port-level checks for the sender window, bound onto the top level.
// Depends on srsw_pkg and selective_repeat_sender_window_defines.svh.
`include "selective_repeat_sender_window_defines.svh"

module srsw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input srsw_pkg::out_item_t out_item_i
);
  import srsw_pkg::*;

  `SRSW_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "stalled result changed")
  `SRSW_ASSERT_NXT(a_one_request, in_valid_i && in_ready_i, !in_ready_i, "second request taken while busy")
  `SRSW_ASSERT_IMP(a_status_shape, out_valid_i && !out_item_i.kind, out_item_i.last && (out_item_i.frame_seq == '0), "bad status item")
  `SRSW_ASSERT_IMP(a_frame_shape, out_valid_i && out_item_i.kind, !out_item_i.done_res && !out_item_i.ack_matched && (out_item_i.sent_count != '0), "bad frame item")

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_chan.valid),
  .in_ready_i  (in_chan.ready),
  .out_valid_i (out_chan.valid),
  .out_ready_i (out_chan.ready),
  .out_item_i  (out_chan.payload)
);
